[sv/bcu_pkg.sv]
// Shared types and constants for the branch condition unit.
// No dependencies; imported by every module of the block.
package bcu_pkg;

	localparam int ADDR_W  = 32;
	localparam int WORD_W  = 16;
	localparam int CYC_W   = 8;
	localparam int EXTRA_W = 4;
	localparam int EXT_W   = 2;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 3;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDE_EN    = 3'd0,
		CFG_CALL_CYC   = 3'd1,
		CFG_TAKEN_CYC  = 3'd2,
		CFG_SHORT_CYC  = 3'd3,
		CFG_LONG_CYC   = 3'd4
	} cfg_idx_t;

	// Condition field, opcode bits 11-8
	typedef enum logic [3:0] {
		CC_T  = 4'h0,
		CC_SR = 4'h1,
		CC_HI = 4'h2,
		CC_LS = 4'h3,
		CC_CC = 4'h4,
		CC_CS = 4'h5,
		CC_NE = 4'h6,
		CC_EQ = 4'h7,
		CC_VC = 4'h8,
		CC_VS = 4'h9,
		CC_PL = 4'hA,
		CC_MI = 4'hB,
		CC_GE = 4'hC,
		CC_LT = 4'hD,
		CC_GT = 4'hE,
		CC_LE = 4'hF
	} cond_t;

	localparam logic [7:0]         DISP_WIDE_SEL = 8'hFF;
	localparam logic [7:0]         DISP_EXT_SEL  = 8'h00;
	localparam logic [ADDR_W-1:0]  PUSH_BYTES    = 32'd4;
	localparam logic [EXTRA_W-1:0] EXTRA_CALL    = 4'd10;
	localparam logic [EXTRA_W-1:0] EXTRA_ODD     = 4'd2;
	localparam logic [EXT_W-1:0]   EXT_NONE      = 2'd0;
	localparam logic [EXT_W-1:0]   EXT_ONE       = 2'd1;
	localparam logic [EXT_W-1:0]   EXT_TWO       = 2'd2;

	localparam logic [CYC_W-1:0] RST_CALL_CYC  = 8'd18;
	localparam logic [CYC_W-1:0] RST_TAKEN_CYC = 8'd10;
	localparam logic [CYC_W-1:0] RST_SHORT_CYC = 8'd8;
	localparam logic [CYC_W-1:0] RST_LONG_CYC  = 8'd12;

	typedef struct packed {
		logic              wide_en;
		logic [CYC_W-1:0]  call_cyc;
		logic [CYC_W-1:0]  taken_cyc;
		logic [CYC_W-1:0]  short_cyc;
		logic [CYC_W-1:0]  long_cyc;
	} cfg_t;

	// Members listed last field first, so the first field lands in the low bits
	typedef struct packed {
		logic [ADDR_W-1:0] stack_pointer;
		logic              flag_c;
		logic              flag_v;
		logic              flag_z;
		logic              flag_n;
		logic [WORD_W-1:0] ext_low_word;
		logic [WORD_W-1:0] ext_high_word;
		logic [ADDR_W-1:0] next_address;
		logic [WORD_W-1:0] opcode;
	} req_t;

	typedef struct packed {
		logic [EXTRA_W-1:0] extra_cycles;
		logic [CYC_W-1:0]   base_cycles;
		logic [EXT_W-1:0]   ext_words_used;
		logic               address_error;
		logic [ADDR_W-1:0]  new_stack_pointer;
		logic [ADDR_W-1:0]  push_data;
		logic [ADDR_W-1:0]  push_address;
		logic               push_valid;
		logic               branch_taken;
		logic [ADDR_W-1:0]  new_pc;
	} res_t;

	localparam int REQ_W  = $bits(req_t);
	localparam int RES_W  = $bits(res_t);
	localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

[sv/bcu_cfg_regs.sv]
// Configuration register file of the branch condition unit.
// Depends on bcu_pkg.
module bcu_cfg_regs
	import bcu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide_en   <= 1'b0;
			cfg_q.call_cyc  <= RST_CALL_CYC;
			cfg_q.taken_cyc <= RST_TAKEN_CYC;
			cfg_q.short_cyc <= RST_SHORT_CYC;
			cfg_q.long_cyc  <= RST_LONG_CYC;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDE_EN:   cfg_q.wide_en   <= cfg_data[0];
				CFG_CALL_CYC:  cfg_q.call_cyc  <= cfg_data;
				CFG_TAKEN_CYC: cfg_q.taken_cyc <= cfg_data;
				CFG_SHORT_CYC: cfg_q.short_cyc <= cfg_data;
				CFG_LONG_CYC:  cfg_q.long_cyc  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/bcu_exec.sv]
// Single-pass branch evaluation: displacement select, condition test,
// target and stack arithmetic. Depends on bcu_pkg.
module bcu_exec
	import bcu_pkg::*;
(
	input  req_t req,
	input  cfg_t cfg,
	output res_t res
);

	logic [7:0]        low_byte;
	cond_t             code;
	logic              wide_sel;
	logic [ADDR_W-1:0] disp;
	logic [EXT_W-1:0]  ext;
	logic [ADDR_W-1:0] target;
	logic [ADDR_W-1:0] seq_pc;
	logic [ADDR_W-1:0] sp_dec;
	logic              cond_ok;
	logic              is_call;
	logic              taken;
	logic              odd;

	assign low_byte = req.opcode[7:0];
	assign code     = cond_t'(req.opcode[11:8]);
	assign wide_sel = (low_byte == DISP_WIDE_SEL) && cfg.wide_en;

	always_comb begin
		if (wide_sel) begin
			disp = {req.ext_high_word, req.ext_low_word};
			ext  = EXT_TWO;
		end else if (low_byte != DISP_EXT_SEL) begin
			disp = {{(ADDR_W-8){low_byte[7]}}, low_byte};
			ext  = EXT_NONE;
		end else begin
			disp = {{(ADDR_W-WORD_W){req.ext_high_word[WORD_W-1]}}, req.ext_high_word};
			ext  = EXT_ONE;
		end
	end

	always_comb begin
		unique case (code)
			CC_T:    cond_ok = 1'b1;
			CC_SR:   cond_ok = 1'b0;
			CC_HI:   cond_ok = !req.flag_c && !req.flag_z;
			CC_LS:   cond_ok = req.flag_c || req.flag_z;
			CC_CC:   cond_ok = !req.flag_c;
			CC_CS:   cond_ok = req.flag_c;
			CC_NE:   cond_ok = !req.flag_z;
			CC_EQ:   cond_ok = req.flag_z;
			CC_VC:   cond_ok = !req.flag_v;
			CC_VS:   cond_ok = req.flag_v;
			CC_PL:   cond_ok = !req.flag_n;
			CC_MI:   cond_ok = req.flag_n;
			CC_GE:   cond_ok = req.flag_n == req.flag_v;
			CC_LT:   cond_ok = req.flag_n != req.flag_v;
			CC_GT:   cond_ok = (req.flag_n == req.flag_v) && !req.flag_z;
			CC_LE:   cond_ok = req.flag_z || (req.flag_n != req.flag_v);
			default: cond_ok = 1'b0;
		endcase
	end

	assign target  = req.next_address + disp;
	assign seq_pc  = req.next_address + {{(ADDR_W-EXT_W-1){1'b0}}, ext, 1'b0};
	assign sp_dec  = req.stack_pointer - PUSH_BYTES;
	assign is_call = (code == CC_SR);
	assign taken   = is_call || cond_ok;
	assign odd     = taken && target[0];

	always_comb begin
		res.new_pc            = taken ? target : seq_pc;
		res.branch_taken      = taken;
		res.push_valid        = is_call;
		res.push_address      = is_call ? sp_dec : '0;
		res.push_data         = is_call ? seq_pc : '0;
		res.new_stack_pointer = is_call ? sp_dec : req.stack_pointer;
		res.address_error     = odd;
		res.ext_words_used    = ext;
		if (is_call) begin
			res.base_cycles  = cfg.call_cyc;
			res.extra_cycles = EXTRA_CALL;
		end else if (taken) begin
			res.base_cycles  = cfg.taken_cyc;
			res.extra_cycles = odd ? EXTRA_ODD : '0;
		end else begin
			res.base_cycles  = (ext == EXT_NONE) ? cfg.short_cyc : cfg.long_cyc;
			res.extra_cycles = '0;
		end
	end

endmodule

[sv/branch_on_condition_unit_top.sv]
// Branch condition unit: one conditional or subroutine branch per request,
// through an input register, a combinational evaluation stage and a result
// register. Accepts a request every clock unless the downstream side stalls;
// a result is presented from the result register once its request has passed
// the input register, and is held while the downstream side stalls, the input
// stage still taking one more request meanwhile. Only that stall limits the
// rate. Configuration writes take effect on the next cycle and are meant for
// when no request is in flight. Depends on bcu_pkg, bcu_cfg_regs and bcu_exec.
module branch_on_condition_unit_top
	import bcu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// opcode, next_address, ext_high_word, ext_low_word, flag_n, flag_z,
	// flag_v, flag_c, stack_pointer, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// new_pc, branch_taken, push_valid, push_address, push_data,
	// new_stack_pointer, address_error, ext_words_used, base_cycles,
	// extra_cycles, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t cfg;
	req_t req_s1;
	res_t res_s2;
	res_t res_c;
	logic vld_s1;
	logic vld_s2;
	logic adv_s2;

	bcu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcu_exec u_exec (
		.req (req_s1),
		.cfg (cfg),
		.res (res_c)
	);

	// stage 2 can load when empty or being drained this cycle
	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			req_s1 <= req_t'(s_tdata[REQ_W-1:0]);
		if (adv_s2 && vld_s1)
			res_s2 <= res_c;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_s2};

endmodule

[tb/tb.sv]
// Self-checking bench for branch_on_condition_unit_top: drives branch requests on the
// input stream, predicts each result and compares it field by field on the output stream.
// Depends on bcu_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
	import bcu_pkg::*;

	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASE_ITEMS     = 130;

	// Predicts branch outcomes and holds those not yet seen on the output
	class branch_outcome_tracker;
		logic       wide_en;
		logic [7:0] call_cyc;
		logic [7:0] taken_cyc;
		logic [7:0] short_nt_cyc;
		logic [7:0] long_nt_cyc;
		res_t       pending_outcomes[$];
		int         mismatches;

		function new();
			wide_en      = 1'b0;
			call_cyc     = RST_CALL_CYC;
			taken_cyc    = RST_TAKEN_CYC;
			short_nt_cyc = RST_SHORT_CYC;
			long_nt_cyc  = RST_LONG_CYC;
			mismatches   = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [7:0] val);
			case (idx)
				CFG_WIDE_EN:   wide_en = val[0];
				CFG_CALL_CYC:  call_cyc = val;
				CFG_TAKEN_CYC: taken_cyc = val;
				CFG_SHORT_CYC: short_nt_cyc = val;
				CFG_LONG_CYC:  long_nt_cyc = val;
				default: ;
			endcase
		endfunction

		function bit condition_holds(cond_t cc, bit n, bit z, bit v, bit c);
			case (cc)
				CC_T:    return 1'b1;
				CC_SR:   return 1'b0;
				CC_HI:   return !c && !z;
				CC_LS:   return c || z;
				CC_CC:   return !c;
				CC_CS:   return c;
				CC_NE:   return !z;
				CC_EQ:   return z;
				CC_VC:   return !v;
				CC_VS:   return v;
				CC_PL:   return !n;
				CC_MI:   return n;
				CC_GE:   return n == v;
				CC_LT:   return n != v;
				CC_GT:   return (n == v) && !z;
				default: return z || (n != v);
			endcase
		endfunction

		function res_t predict_outcome(req_t r);
			res_t        e;
			logic [31:0] disp;
			logic [31:0] target;
			logic [31:0] seq;
			logic [1:0]  ext;
			logic [7:0]  low;
			cond_t       cc;
			low = r.opcode[7:0];
			cc  = cond_t'(r.opcode[11:8]);
			if (low == DISP_WIDE_SEL && wide_en) begin
				disp = {r.ext_high_word, r.ext_low_word};
				ext  = EXT_TWO;
			end else if (low != DISP_EXT_SEL) begin
				disp = {{24{low[7]}}, low};
				ext  = EXT_NONE;
			end else begin
				disp = {{16{r.ext_high_word[15]}}, r.ext_high_word};
				ext  = EXT_ONE;
			end
			target = r.next_address + disp;
			seq    = r.next_address + {29'd0, ext, 1'b0};
			e = '0;
			e.new_stack_pointer = r.stack_pointer;
			e.ext_words_used    = ext;
			if (cc == CC_SR) begin
				e.branch_taken      = 1'b1;
				e.push_valid        = 1'b1;
				e.push_address      = r.stack_pointer - PUSH_BYTES;
				e.push_data         = seq;
				e.new_stack_pointer = e.push_address;
				e.new_pc            = target;
				e.address_error     = target[0];
				e.base_cycles       = call_cyc;
				e.extra_cycles      = EXTRA_CALL;
			end else if (condition_holds(cc, r.flag_n, r.flag_z, r.flag_v, r.flag_c)) begin
				e.branch_taken  = 1'b1;
				e.new_pc        = target;
				e.address_error = target[0];
				e.base_cycles   = taken_cyc;
				e.extra_cycles  = target[0] ? EXTRA_ODD : '0;
			end else begin
				e.new_pc      = seq;
				e.base_cycles = (ext == EXT_NONE) ? short_nt_cyc : long_nt_cyc;
			end
			return e;
		endfunction

		function void note_request(req_t r);
			pending_outcomes.push_back(predict_outcome(r));
		endfunction

		function int pending();
			return pending_outcomes.size();
		endfunction

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			mismatches++;
		endtask

		task cmp(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s: got %h, want %h", field, got, want));
		endtask

		task check_outcome(res_t got);
			res_t want;
			if (pending_outcomes.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = pending_outcomes.pop_front();
			cmp("new_pc", got.new_pc, want.new_pc);
			cmp("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
			cmp("push_valid", 32'(got.push_valid), 32'(want.push_valid));
			cmp("push_address", got.push_address, want.push_address);
			cmp("push_data", got.push_data, want.push_data);
			cmp("new_stack_pointer", got.new_stack_pointer, want.new_stack_pointer);
			cmp("address_error", 32'(got.address_error), 32'(want.address_error));
			cmp("ext_words_used", 32'(got.ext_words_used), 32'(want.ext_words_used));
			cmp("base_cycles", 32'(got.base_cycles), 32'(want.base_cycles));
			cmp("extra_cycles", 32'(got.extra_cycles), 32'(want.extra_cycles));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	branch_outcome_tracker tracker;
	bit no_idle = 1'b0;
	bit hold_off_pending = 1'b0;

	branch_on_condition_unit_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_t make_req(logic [15:0] opcode, logic [31:0] next_addr,
			logic [15:0] hi, logic [15:0] lo, logic [3:0] nzvc, logic [31:0] sp);
		req_t r;
		r.opcode        = opcode;
		r.next_address  = next_addr;
		r.ext_high_word = hi;
		r.ext_low_word  = lo;
		{r.flag_n, r.flag_z, r.flag_v, r.flag_c} = nzvc;
		r.stack_pointer = sp;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		r = make_req(16'($urandom), $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
			$urandom);
		// lean on the two extension-word selectors
		pick = $urandom_range(99);
		if (pick < 25)
			r.opcode[7:0] = DISP_EXT_SEL;
		else if (pick < 45)
			r.opcode[7:0] = DISP_WIDE_SEL;
		if ($urandom_range(9) == 0)
			r.next_address = 32'hFFFF_FFFF - $urandom_range(15);
		if ($urandom_range(9) == 0)
			r.stack_pointer = $urandom_range(7);
		return r;
	endfunction

	// Holds the request until it is taken; called just after a rising edge
	task automatic send_request(req_t r);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[REQ_W-1:0] = r;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(r);
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			if (!no_idle && $urandom_range(99) < 9) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(3, 1)) @(posedge clk);
			end
			send_request(random_request());
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(logic wide, logic [7:0] call_c, logic [7:0] taken_c,
			logic [7:0] snt_c, logic [7:0] lnt_c);
		logic [7:0] vals [5];
		vals[CFG_WIDE_EN]   = {7'd0, wide};
		vals[CFG_CALL_CYC]  = call_c;
		vals[CFG_TAKEN_CYC] = taken_c;
		vals[CFG_SHORT_CYC] = snt_c;
		vals[CFG_LONG_CYC]  = lnt_c;
		for (int i = CFG_WIDE_EN; i <= CFG_LONG_CYC; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			tracker.set_reg(cfg_idx_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_outcome(res_t'(m_tdata[RES_W-1:0]));
	end

	// Output side back-pressure; a requested hold-off is counted here
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 9);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("branch_on_condition_unit_top: mismatch");
		$finish;
	end

	initial begin
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: narrow mode, default cycle counts
		send_request(make_req({4'h0, CC_T, 8'h01}, 32'h0, 16'h0, 16'h0, 4'h0, 32'h1000));
		// call wrapping both the target and the stack pointer
		send_request(make_req({4'hF, CC_SR, 8'h7F}, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF,
			4'hF, 32'h0));
		// odd call target through a negative 16-bit word
		send_request(make_req({4'h0, CC_SR, 8'h00}, 32'h0000_1001, 16'h8000, 16'hFFFF,
			4'h0, 32'hFFFF_FFFF));
		send_request(make_req({4'hA, CC_HI, 8'h80}, 32'h8000_0000, 16'h1234, 16'h0,
			4'b0001, 32'h10));
		send_request(make_req({4'h5, CC_LE, 8'h00}, 32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF,
			4'b0000, 32'hFFFF_FFFC));
		// 0xFF is a plain -1 while wide mode is off
		send_request(make_req({4'h0, CC_T, 8'hFF}, 32'h100, 16'hFFFF, 16'hFFFF, 4'h0,
			32'h2000));
		send_request(make_req({4'hC, CC_LE, 8'hFF}, 32'h0, 16'h0, 16'h0, 4'b1000,
			32'h2000));
		for (int k = 0; k < 16; k++)
			send_request(make_req({4'(k), 4'(k), 8'(2 * k + 2)}, $urandom, 16'($urandom),
				16'($urandom), 4'(k), $urandom));
		s_tvalid <= 1'b0;
		wait_idle();

		apply_settings(1'b1, 8'd255, 8'd0, 8'd255, 8'd0);
		send_request(make_req({4'h0, CC_SR, 8'hFF}, 32'h0000_4000, 16'hFFFF, 16'hFFFE,
			4'h0, 32'h0000_0100));
		send_request(make_req({4'h3, CC_EQ, 8'hFF}, 32'hFFFF_FFFE, 16'h8000, 16'h0001,
			4'h0, 32'h0000_0100));
		run_random(PHASE_ITEMS);
		wait_idle();

		for (int p = 1; p <= 4; p++) begin
			case (p)
				1: apply_settings(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
				2: apply_settings(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
				default: apply_settings(1'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			endcase
			if (p == 3) begin
				// steady stream while the output side holds off, so the input stalls
				no_idle = 1'b1;
				hold_off_pending = 1'b1;
			end
			run_random(PHASE_ITEMS);
			wait_idle();
			no_idle = 1'b0;
		end

		if (tracker.mismatches == 0)
			$display("branch_on_condition_unit_top: match");
		else
			$display("branch_on_condition_unit_top: mismatch");
		$finish;
	end

endmodule
